FILE: rtl/dpp_pkg.sv
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types, register codes and reset calibration of the depth pixel to
// point unit.
// ----------------------------------------------------------------------------
package dpp_pkg;

	localparam int DEFAULT_COORD_BITS      = 12;
	localparam int DEFAULT_RECIP_FRAC_BITS = 24;
	localparam int DEFAULT_QUEUE_DEPTH     = 4;

	localparam int DEPTH_W    = 16;
	localparam int CENTER_W   = 16;
	localparam int RECIP_W    = 24;
	localparam int RECIP_LO_W = 12;
	localparam int RECIP_HI_W = RECIP_W - RECIP_LO_W;
	localparam int POINT_W    = 32;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int NUM_STAGES = 5;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_INV_FOCAL_X  = 3'd0,
		REG_INV_FOCAL_Y  = 3'd1,
		REG_CENTER_X_Q4  = 3'd2,
		REG_CENTER_Y_Q4  = 3'd3,
		REG_INVALID_CODE = 3'd4
	} reg_idx_t;

	localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_X  = 24'd46320;
	localparam logic [RECIP_W-1:0]  RST_INV_FOCAL_Y  = 24'd46155;
	localparam logic [CENTER_W-1:0] RST_CENTER_X_Q4  = 16'd5120;
	localparam logic [CENTER_W-1:0] RST_CENTER_Y_Q4  = 16'd3840;
	localparam logic [DEPTH_W-1:0]  RST_INVALID_CODE = 16'd4096;

	typedef struct packed {
		logic [RECIP_W-1:0]  inv_focal_x;
		logic [RECIP_W-1:0]  inv_focal_y;
		logic [CENTER_W-1:0] center_x_q4;
		logic [CENTER_W-1:0] center_y_q4;
		logic [DEPTH_W-1:0]  invalid_code;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

FILE: rtl/dpp_queue.sv
// ----------------------------------------------------------------------------
// dpp_queue
// Short first-in first-out queue between the classifying front and the
// projection back end.
// ----------------------------------------------------------------------------
module dpp_queue #(
	parameter int WIDTH = 58,
	parameter int DEPTH = dpp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 rd,
	output logic [WIDTH-1:0]     rdata,
	output dpp_pkg::q_status_t   status
);
	import dpp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign rdata        = mem_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));

endmodule

FILE: rtl/dpp_front.sv
// ----------------------------------------------------------------------------
// dpp_front
// Drops empty and invalid depth samples and forms the signed pixel offsets
// from the principal point as sign and magnitude.
// ----------------------------------------------------------------------------
module dpp_front #(
	parameter int COORD_BITS = dpp_pkg::DEFAULT_COORD_BITS,
	parameter int MAG_W      = 16
) (
	input  logic                         accept,
	input  dpp_pkg::cfg_t                cfg,
	input  logic [dpp_pkg::DEPTH_W-1:0]  pixel_depth,
	input  logic [COORD_BITS-1:0]        pixel_col,
	input  logic [COORD_BITS-1:0]        pixel_row,
	output logic                         wr,
	output logic [MAG_W-1:0]             mag_x,
	output logic                         neg_x,
	output logic [MAG_W-1:0]             mag_y,
	output logic                         neg_y
);
	import dpp_pkg::*;

	logic [MAG_W-1:0] pos_x, pos_y, ctr_x, ctr_y;

	assign wr = accept && (pixel_depth != '0) && (pixel_depth != cfg.invalid_code);

	always_comb begin
		pos_x = MAG_W'({pixel_col, 4'b0000});
		pos_y = MAG_W'({pixel_row, 4'b0000});
		ctr_x = MAG_W'(cfg.center_x_q4);
		ctr_y = MAG_W'(cfg.center_y_q4);
		neg_x = pos_x < ctr_x;
		neg_y = pos_y < ctr_y;
		mag_x = neg_x ? (ctr_x - pos_x) : (pos_x - ctr_x);
		mag_y = neg_y ? (ctr_y - pos_y) : (pos_y - ctr_y);
	end

endmodule

FILE: rtl/dpp_axis.sv
// ----------------------------------------------------------------------------
// dpp_axis
// Datapath of one coordinate: offset times depth times reciprocal focal
// length, rounded to nearest and saturated to 32 bits.
// ----------------------------------------------------------------------------
module dpp_axis #(
	parameter int MAG_W           = 16,
	parameter int RECIP_FRAC_BITS = dpp_pkg::DEFAULT_RECIP_FRAC_BITS
) (
	input  logic                            clk,
	input  logic [dpp_pkg::NUM_STAGES-1:0]  stage_en,
	input  logic [MAG_W-1:0]                mag,
	input  logic                            neg,
	input  logic [dpp_pkg::DEPTH_W-1:0]     depth,
	input  logic [dpp_pkg::RECIP_W-1:0]     recip,
	output logic [dpp_pkg::POINT_W-1:0]     point
);
	import dpp_pkg::*;

	localparam int P1_W   = MAG_W + DEPTH_W;
	localparam int LO_W   = P1_W + RECIP_LO_W;
	localparam int HI_W   = P1_W + RECIP_HI_W;
	localparam int PROD_W = P1_W + RECIP_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;

	logic [MAG_W-1:0]   mag_s1;
	logic [DEPTH_W-1:0] depth_s1;
	logic [P1_W-1:0]    p1_s2, p1_s3;
	logic [LO_W-1:0]    lo_s3, lo_s4;
	logic [HI_W-1:0]    hi_s4;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic [POINT_W-1:0] point_s5;

	logic [SUM_W-1:0]   sum;
	logic [63:0]        q_ext;
	logic [31:0]        sat;

	always_comb begin
		sum = SUM_W'({hi_s4, {RECIP_LO_W{1'b0}}}) + SUM_W'(lo_s4)
			+ (SUM_W'(1) << (RECIP_FRAC_BITS - 1));
		q_ext = 64'(sum >> RECIP_FRAC_BITS);
		if (neg_s4) begin
			sat = (q_ext > NEG_LIMIT) ? NEG_LIMIT[31:0] : q_ext[31:0];
		end else begin
			sat = (q_ext > POS_LIMIT) ? POS_LIMIT[31:0] : q_ext[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			mag_s1   <= mag;
			neg_s1   <= neg;
			depth_s1 <= depth;
		end
		if (stage_en[1]) begin
			p1_s2  <= P1_W'(mag_s1) * P1_W'(depth_s1);
			neg_s2 <= neg_s1;
		end
		if (stage_en[2]) begin
			lo_s3  <= LO_W'(p1_s2) * LO_W'(recip[RECIP_LO_W-1:0]);
			p1_s3  <= p1_s2;
			neg_s3 <= neg_s2;
		end
		if (stage_en[3]) begin
			hi_s4  <= HI_W'(p1_s3) * HI_W'(recip[RECIP_W-1:RECIP_LO_W]);
			lo_s4  <= lo_s3;
			neg_s4 <= neg_s3;
		end
		if (stage_en[4]) begin
			point_s5 <= neg_s4 ? (32'd0 - sat) : sat;
		end
	end

	assign point = point_s5;

endmodule

FILE: rtl/dpp_back.sv
// ----------------------------------------------------------------------------
// dpp_back
// Projection back end: drains the queue into a five stage stallable
// pipeline whose last stage is the result register.
// ----------------------------------------------------------------------------
module dpp_back #(
	parameter int MAG_W           = 16,
	parameter int RECIP_FRAC_BITS = dpp_pkg::DEFAULT_RECIP_FRAC_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dpp_pkg::cfg_t                 cfg,
	input  dpp_pkg::q_status_t            q_status,
	input  logic [MAG_W-1:0]              mag_x,
	input  logic                          neg_x,
	input  logic [MAG_W-1:0]              mag_y,
	input  logic                          neg_y,
	input  logic [dpp_pkg::DEPTH_W-1:0]   depth,
	output logic                          q_rd,
	input  logic                          pop,
	output logic                          empty,
	output logic [dpp_pkg::POINT_W-1:0]   point_x_q4,
	output logic [dpp_pkg::POINT_W-1:0]   point_y_q4,
	output logic [dpp_pkg::DEPTH_W-1:0]   point_z_mm
);
	import dpp_pkg::*;

	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] stage_en;
	logic [DEPTH_W-1:0]    z_q [NUM_STAGES];

	// a stage moves on when it is empty or the one after it moves
	always_comb begin
		stage_en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || pop;
		for (int i = NUM_STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !valid_q[i] || stage_en[i+1];
		end
	end

	assign q_rd = stage_en[0] && !q_status.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (stage_en[0]) begin
				valid_q[0] <= !q_status.empty;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (stage_en[i]) begin
					valid_q[i] <= valid_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			z_q[0] <= depth;
		end
		for (int i = 1; i < NUM_STAGES; i++) begin
			if (stage_en[i]) begin
				z_q[i] <= z_q[i-1];
			end
		end
	end

	dpp_axis #(
		.MAG_W           (MAG_W),
		.RECIP_FRAC_BITS (RECIP_FRAC_BITS)
	) u_axis_x (
		.clk      (clk),
		.stage_en (stage_en),
		.mag      (mag_x),
		.neg      (neg_x),
		.depth    (depth),
		.recip    (cfg.inv_focal_x),
		.point    (point_x_q4)
	);

	dpp_axis #(
		.MAG_W           (MAG_W),
		.RECIP_FRAC_BITS (RECIP_FRAC_BITS)
	) u_axis_y (
		.clk      (clk),
		.stage_en (stage_en),
		.mag      (mag_y),
		.neg      (neg_y),
		.depth    (depth),
		.recip    (cfg.inv_focal_y),
		.point    (point_y_q4)
	);

	assign empty      = !valid_q[NUM_STAGES-1];
	assign point_z_mm = z_q[NUM_STAGES-1];

endmodule

FILE: rtl/depth_pixel_to_point_unit.sv
// ----------------------------------------------------------------------------
// depth_pixel_to_point_unit
// Pinhole back-projection of depth pixels into points in millimetres.
// ----------------------------------------------------------------------------
// Takes one depth pixel per clock while full is low and gives one point per
// valid pixel, also one per clock while pop is high; pixels with zero depth or
// the invalid code give nothing. The front classifies the pixel and writes a
// short queue in the cycle of the transfer, and the back end runs offset times
// depth, then the reciprocal multiply in two halves, then rounding and
// saturation, each in a stage of its own. While results are not taken the back
// end fills and then the queue, after which full rises.
module depth_pixel_to_point_unit #(
	parameter int COORD_BITS      = dpp_pkg::DEFAULT_COORD_BITS,
	parameter int RECIP_FRAC_BITS = dpp_pkg::DEFAULT_RECIP_FRAC_BITS,
	parameter int QUEUE_DEPTH     = dpp_pkg::DEFAULT_QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dpp_pkg::CFG_ADDR_W-1:0]  cfg_index,
	input  logic [dpp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            push,
	output logic                            full,
	input  logic [dpp_pkg::DEPTH_W-1:0]     pixel_depth,
	input  logic [COORD_BITS-1:0]           pixel_col,
	input  logic [COORD_BITS-1:0]           pixel_row,
	output logic                            empty,
	input  logic                            pop,
	output logic signed [dpp_pkg::POINT_W-1:0] point_x_q4,
	output logic signed [dpp_pkg::POINT_W-1:0] point_y_q4,
	output logic [dpp_pkg::DEPTH_W-1:0]     point_z_mm
);
	import dpp_pkg::*;

	localparam int MAG_W   = (COORD_BITS + 4 > CENTER_W) ? COORD_BITS + 4 : CENTER_W;
	localparam int ENTRY_W = 2 * MAG_W + 2 + DEPTH_W;

	cfg_t             cfg_q;
	q_status_t        q_status;
	logic             accept;
	logic             q_wr, q_rd;
	logic [MAG_W-1:0] f_mag_x, f_mag_y, b_mag_x, b_mag_y;
	logic             f_neg_x, f_neg_y, b_neg_x, b_neg_y;
	logic [DEPTH_W-1:0] b_depth;
	logic [ENTRY_W-1:0] q_rdata;
	logic [POINT_W-1:0] px, py;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_focal_x  <= RST_INV_FOCAL_X;
			cfg_q.inv_focal_y  <= RST_INV_FOCAL_Y;
			cfg_q.center_x_q4  <= RST_CENTER_X_Q4;
			cfg_q.center_y_q4  <= RST_CENTER_Y_Q4;
			cfg_q.invalid_code <= RST_INVALID_CODE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_FOCAL_X:  cfg_q.inv_focal_x  <= cfg_wdata[RECIP_W-1:0];
				REG_INV_FOCAL_Y:  cfg_q.inv_focal_y  <= cfg_wdata[RECIP_W-1:0];
				REG_CENTER_X_Q4:  cfg_q.center_x_q4  <= cfg_wdata[CENTER_W-1:0];
				REG_CENTER_Y_Q4:  cfg_q.center_y_q4  <= cfg_wdata[CENTER_W-1:0];
				REG_INVALID_CODE: cfg_q.invalid_code <= cfg_wdata[DEPTH_W-1:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	assign full   = q_status.full;
	assign accept = push && !q_status.full;

	dpp_front #(
		.COORD_BITS (COORD_BITS),
		.MAG_W      (MAG_W)
	) u_front (
		.accept      (accept),
		.cfg         (cfg_q),
		.pixel_depth (pixel_depth),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.wr          (q_wr),
		.mag_x       (f_mag_x),
		.neg_x       (f_neg_x),
		.mag_y       (f_mag_y),
		.neg_y       (f_neg_y)
	);

	dpp_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wdata  ({pixel_depth, f_neg_y, f_mag_y, f_neg_x, f_mag_x}),
		.rd     (q_rd),
		.rdata  (q_rdata),
		.status (q_status)
	);

	assign {b_depth, b_neg_y, b_mag_y, b_neg_x, b_mag_x} = q_rdata;

	dpp_back #(
		.MAG_W           (MAG_W),
		.RECIP_FRAC_BITS (RECIP_FRAC_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_status   (q_status),
		.mag_x      (b_mag_x),
		.neg_x      (b_neg_x),
		.mag_y      (b_mag_y),
		.neg_y      (b_neg_y),
		.depth      (b_depth),
		.q_rd       (q_rd),
		.pop        (pop),
		.empty      (empty),
		.point_x_q4 (px),
		.point_y_q4 (py),
		.point_z_mm (point_z_mm)
	);

	assign point_x_q4 = signed'(px);
	assign point_y_q4 = signed'(py);

`ifndef SYNTHESIS
	// a dropped pixel never reaches the queue
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (pixel_depth == '0 || pixel_depth == cfg_q.invalid_code)) |-> !q_wr)
		else $error("dropped pixel written to queue");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_status.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_rd |-> !q_status.empty)
		else $error("queue read while empty");

	// only nonzero depths come out
	a_z_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> point_z_mm != '0)
		else $error("result with zero depth");
`endif

endmodule

FILE: sim/tb_depth_pixel_to_point_unit.sv
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_point_unit
// Self-checking bench for the pinhole back-projection of depth pixels.
// ----------------------------------------------------------------------------
// Pixels are fed from a queue by a bursty driver. Each accepted valid pixel is run
// through a local fixed-point projection with the bench's copy of the
// calibration registers, and the expected point is queued. A monitor that
// stalls in changing patterns takes the points and compares them field by
// field. The calibration is rewritten between phases, only while idle.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_point_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dpp_pkg::*;

	localparam int COORD_W      = DEFAULT_COORD_BITS;
	localparam int FRAC_BITS    = DEFAULT_RECIP_FRAC_BITS;
	localparam int NUM_REGS     = 5;
	localparam int DRAIN_CYCLES = 3 * NUM_STAGES;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_SETS  = 8;
	localparam int SET_POINTS   = 170;
	localparam int PRINT_CAP    = 40;

	localparam logic [RECIP_W-1:0]  RECIP_MAX  = '1;
	localparam logic [RECIP_W-1:0]  RECIP_HALF = RECIP_W'(1) << (RECIP_W - 1);
	localparam logic [CENTER_W-1:0] CENTER_MAX = '1;
	localparam logic [DEPTH_W-1:0]  DEPTH_MAX  = '1;
	localparam logic [DEPTH_W-1:0]  NO_DEPTH   = '0;
	localparam logic [COORD_W-1:0]  COORD_MAX  = '1;
	localparam logic [63:0]         POS_LIMIT  = 64'h0000_0000_7fff_ffff;
	localparam logic [63:0]         NEG_LIMIT  = 64'h0000_0000_8000_0000;

	typedef struct {
		logic [DEPTH_W-1:0] depth;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
	} pixel_t;

	typedef struct {
		logic signed [POINT_W-1:0] x;
		logic signed [POINT_W-1:0] y;
		logic [DEPTH_W-1:0]        z;
	} point_t;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic push = 1'b0;
	logic full;
	logic [DEPTH_W-1:0] pixel_depth = '0;
	logic [COORD_W-1:0] pixel_col = '0;
	logic [COORD_W-1:0] pixel_row = '0;
	logic empty;
	logic pop = 1'b0;
	logic signed [POINT_W-1:0] point_x_q4;
	logic signed [POINT_W-1:0] point_y_q4;
	logic [DEPTH_W-1:0] point_z_mm;

	cfg_t   cal;
	pixel_t pending_pixels[$];
	point_t expected_points[$];

	int errors = 0;
	int pixels_sent = 0;
	int pixels_dropped = 0;
	int points_checked = 0;
	int settings_used = 0;
	int cycle_count = 0;

	depth_pixel_to_point_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.pixel_depth (pixel_depth),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.empty       (empty),
		.pop         (pop),
		.point_x_q4  (point_x_q4),
		.point_y_q4  (point_y_q4),
		.point_z_mm  (point_z_mm)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report(input string msg);
		if (errors < PRINT_CAP) begin
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		end
		errors++;
	endtask

	// offset times depth times reciprocal, rounded half away from zero, saturated
	function automatic logic [POINT_W-1:0] axis_coord(input logic [COORD_W-1:0] pix,
			input logic [CENTER_W-1:0] center, input logic [DEPTH_W-1:0] depth,
			input logic [RECIP_W-1:0] recip);
		logic [63:0] pos;
		logic [63:0] mag;
		logic [63:0] prod;
		logic [63:0] q;
		logic [63:0] res;
		logic        neg;
		pos  = 64'(pix) << 4;
		neg  = pos < 64'(center);
		mag  = neg ? 64'(center) - pos : pos - 64'(center);
		prod = mag * 64'(depth) * 64'(recip);
		q    = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (neg) begin
			if (q > NEG_LIMIT) q = NEG_LIMIT;
			res = 64'd0 - q;
		end else begin
			if (q > POS_LIMIT) q = POS_LIMIT;
			res = q;
		end
		return res[POINT_W-1:0];
	endfunction

	function automatic point_t project_pixel(input pixel_t px, input cfg_t c);
		point_t pt;
		pt.x = axis_coord(px.col, c.center_x_q4, px.depth, c.inv_focal_x);
		pt.y = axis_coord(px.row, c.center_y_q4, px.depth, c.inv_focal_y);
		pt.z = px.depth;
		return pt;
	endfunction

	// ---------------------------------------------------------------- driver
	int     burst_left = 0;
	int     gap_left = 0;
	logic   push_next;
	pixel_t taken_px;

	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			push_next = push;
			if (push && !full) begin
				taken_px.depth = pixel_depth;
				taken_px.col   = pixel_col;
				taken_px.row   = pixel_row;
				if (pixel_depth == NO_DEPTH || pixel_depth == cal.invalid_code) begin
					pixels_dropped++;
				end else begin
					expected_points.insert(expected_points.size(),
						project_pixel(taken_px, cal));
				end
				void'(pending_pixels.pop_front());
				pixels_sent++;
				push_next = 1'b0;
			end
			if (!push_next) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_pixels.size() > 0) begin
					push_next = 1'b1;
					pixel_depth <= pending_pixels[0].depth;
					pixel_col   <= pending_pixels[0].col;
					pixel_row   <= pending_pixels[0].row;
					if (burst_left > 0) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(60, 150);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(0, 30);
						gap_left = $urandom_range(1, 12);
					end
				end
			end
			push <= push_next;
		end
	end

	// --------------------------------------------------------------- monitor
	rx_mode_t rx_mode = RX_STEADY;
	int       rx_left = 0;
	int       rx_phase = 0;
	logic     pop_next;
	point_t   exp_pt;

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_points.size() == 0) begin
					report($sformatf("point (%0d, %0d, %0d) with no pixel behind it",
						point_x_q4, point_y_q4, point_z_mm));
				end else begin
					exp_pt = expected_points.pop_front();
					if (point_x_q4 !== exp_pt.x)
						report($sformatf("x got %0d, expected %0d (z %0d)",
							point_x_q4, exp_pt.x, exp_pt.z));
					if (point_y_q4 !== exp_pt.y)
						report($sformatf("y got %0d, expected %0d (z %0d)",
							point_y_q4, exp_pt.y, exp_pt.z));
					if (point_z_mm !== exp_pt.z)
						report($sformatf("z got %0d, expected %0d", point_z_mm, exp_pt.z));
					points_checked++;
				end
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_STEADY:   pop_next = 1'b1;
				RX_RANDOM:   pop_next = 1'($urandom_range(0, 1));
				RX_SPARSE:   pop_next = ($urandom_range(0, 7) == 0);
				default:     pop_next = (rx_phase < 3);
			endcase
			rx_phase = (rx_phase == 4) ? 0 : rx_phase + 1;
			pop <= pop_next;
		end
	end

	// -------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points outstanding",
				cycle_count, expected_points.size());
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------- stimulus
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_INV_FOCAL_X:  cal.inv_focal_x  = data[RECIP_W-1:0];
			REG_INV_FOCAL_Y:  cal.inv_focal_y  = data[RECIP_W-1:0];
			REG_CENTER_X_Q4:  cal.center_x_q4  = data[CENTER_W-1:0];
			REG_CENTER_Y_Q4:  cal.center_y_q4  = data[CENTER_W-1:0];
			REG_INVALID_CODE: cal.invalid_code = data[DEPTH_W-1:0];
			default: ;
		endcase
	endtask

	// spare upper bits of the 16-bit registers carry noise
	task automatic load_calibration(input logic [RECIP_W-1:0] fx_inv,
			input logic [RECIP_W-1:0] fy_inv, input logic [CENTER_W-1:0] cx,
			input logic [CENTER_W-1:0] cy, input logic [DEPTH_W-1:0] bad_code);
		write_reg(REG_INV_FOCAL_X, fx_inv);
		write_reg(REG_INV_FOCAL_Y, fy_inv);
		write_reg(REG_CENTER_X_Q4, {8'($urandom), cx});
		write_reg(REG_CENTER_Y_Q4, {8'($urandom), cy});
		write_reg(REG_INVALID_CODE, {8'($urandom), bad_code});
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic add_pixel(input logic [DEPTH_W-1:0] depth,
			input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		pixel_t px;
		px.depth = depth;
		px.col   = col;
		px.row   = row;
		pending_pixels.insert(pending_pixels.size(), px);
	endtask

	// dropped pixels leave nothing to wait for, so allow the pipe to empty
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RECIP_W-1:0] pick_recip();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return RECIP_MAX;
			2:       return RECIP_HALF;
			3, 4:    return RECIP_W'($urandom);
			default: return RECIP_W'($urandom_range(20000, 120000));
		endcase
	endfunction

	function automatic logic [CENTER_W-1:0] pick_center();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return CENTER_MAX;
			2, 3:    return CENTER_W'($urandom);
			default: return CENTER_W'($urandom_range(0, 16 * COORD_MAX));
		endcase
	endfunction

	function automatic logic [DEPTH_W-1:0] pick_invalid();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return DEPTH_MAX;
			2:       return RST_INVALID_CODE;
			default: return DEPTH_W'($urandom);
		endcase
	endfunction

	task automatic queue_random_pixels(input int point_target);
		int                 valid;
		logic [DEPTH_W-1:0] d;
		valid = 0;
		while (valid < point_target) begin
			case ($urandom_range(0, 24))
				0:           d = NO_DEPTH;
				1, 2:        d = cal.invalid_code;
				3:           d = DEPTH_MAX;
				4:           d = DEPTH_W'(1);
				5, 6, 7, 8:  d = DEPTH_W'($urandom);
				default:     d = DEPTH_W'($urandom_range(200, 12000));
			endcase
			if (d != NO_DEPTH && d != cal.invalid_code) valid++;
			add_pixel(d, COORD_W'($urandom), COORD_W'($urandom));
		end
	endtask

	initial begin
		cal.inv_focal_x  = RST_INV_FOCAL_X;
		cal.inv_focal_y  = RST_INV_FOCAL_Y;
		cal.center_x_q4  = RST_CENTER_X_Q4;
		cal.center_y_q4  = RST_CENTER_Y_Q4;
		cal.invalid_code = RST_INVALID_CODE;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// fallback calibration straight out of reset
		add_pixel(NO_DEPTH, COORD_W'(100), COORD_W'(100));
		add_pixel(RST_INVALID_CODE, COORD_W'(320), COORD_W'(240));
		add_pixel(DEPTH_W'(RST_INVALID_CODE - 1), COORD_W'(320), COORD_W'(240));
		add_pixel(DEPTH_W'(RST_INVALID_CODE + 1), '0, '0);
		add_pixel(DEPTH_W'(1), COORD_MAX, COORD_MAX);
		add_pixel(DEPTH_MAX, '0, COORD_MAX);
		add_pixel(DEPTH_MAX, COORD_MAX, '0);
		add_pixel(DEPTH_W'(1000), COORD_W'(321), COORD_W'(239));
		wait_idle();

		// writes past the register list must leave the calibration alone
		for (int i = NUM_REGS; i < 2 ** CFG_ADDR_W; i++)
			write_reg(CFG_ADDR_W'(i), CFG_DATA_W'($urandom));
		// full-scale x with centre at zero, y reciprocal zero, only zero depth invalid
		load_calibration(RECIP_MAX, '0, '0, CENTER_MAX, '0);
		add_pixel(NO_DEPTH, COORD_W'(5), COORD_W'(5));
		add_pixel(DEPTH_MAX, COORD_MAX, '0);
		add_pixel(DEPTH_W'(1), '0, COORD_MAX);
		add_pixel(RST_INVALID_CODE, COORD_W'(2048), COORD_W'(2048));
		wait_idle();

		// y driven to negative saturation, top depth code invalid
		load_calibration('0, RECIP_MAX, CENTER_MAX, CENTER_MAX, DEPTH_MAX);
		add_pixel(DEPTH_MAX, COORD_W'(1000), COORD_W'(1000));
		add_pixel(DEPTH_W'(DEPTH_MAX - 1), '0, '0);
		add_pixel(DEPTH_W'(1), COORD_MAX, COORD_MAX);
		add_pixel(NO_DEPTH, COORD_W'(1), COORD_W'(1));
		wait_idle();

		// half reciprocal puts exact ties on the rounding of both signs
		load_calibration(RECIP_HALF, RECIP_HALF, CENTER_W'(1), CENTER_W'(1), DEPTH_W'(1));
		add_pixel(DEPTH_W'(1), '0, '0);
		add_pixel(DEPTH_W'(3), '0, '0);
		add_pixel(DEPTH_W'(3), COORD_W'(1), COORD_W'(1));
		add_pixel(DEPTH_W'(2), '0, COORD_W'(1));
		add_pixel(DEPTH_MAX, COORD_MAX, COORD_MAX);
		wait_idle();

		for (int s = 0; s < RANDOM_SETS; s++) begin
			if (s == RANDOM_SETS - 1)
				load_calibration(RST_INV_FOCAL_X, RST_INV_FOCAL_Y, RST_CENTER_X_Q4,
					RST_CENTER_Y_Q4, RST_INVALID_CODE);
			else
				load_calibration(pick_recip(), pick_recip(), pick_center(),
					pick_center(), pick_invalid());
			queue_random_pixels(SET_POINTS);
			wait_idle();
		end

		if (expected_points.size() != 0)
			report($sformatf("%0d points never arrived", expected_points.size()));
		$display("%0d pixels sent over %0d calibration settings, %0d dropped as invalid",
			pixels_sent, settings_used, pixels_dropped);
		$display("%0d points checked, %0d mismatches", points_checked, errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
